[hdl/cigar_psite_position_mapper_top_assert.svh]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CIGAR_PSITE_POSITION_MAPPER_TOP_ASSERT_SVH
`define CIGAR_PSITE_POSITION_MAPPER_TOP_ASSERT_SVH

// checked only while out of reset
`define CPM_ASSERT_RUN(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cpm assertion failed");

// checked at every edge, reset included
`define CPM_ASSERT_ALL(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("cpm assertion failed during reset");

`endif

[hdl/cpm_pkg.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper package
// Widths, operation classes, queue entry type and saturating helpers.
// ----------------------------------------------------------------------------
package cpm_pkg;

	localparam int COORD_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int START_W  = 31;
	localparam int OFFSET_W = 16;
	localparam int OUT_W    = 32;
	localparam int S_DATA_W = 56;
	localparam int CNT_W    = 8;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = $clog2(Q_DEPTH);

	typedef logic [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = '1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MATCH,
		OP_INS,
		OP_SOFT,
		OP_REFSKIP,
		OP_CLIP
	} op_kind_t;

	typedef struct packed {
		op_kind_t              op;
		coord_t                len;
		logic [START_W-1:0]    start;
		logic [OFFSET_W-1:0]   offset;
		logic                  last;
	} entry_t;

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic [COORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
	endfunction

	function automatic coord_t clip_start(input logic [START_W-1:0] s);
		return (64'(s) > 64'(COORD_MAX)) ? COORD_MAX : coord_t'(s);
	endfunction

endpackage

[hdl/cpm_front.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper front end
// Accepts characters, builds run lengths and queues classified operations.
// ----------------------------------------------------------------------------
module cpm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cpm_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	input  logic                          q_full,
	output logic                          q_push,
	output cpm_pkg::entry_t               q_entry
);

	localparam int ACC_W = cpm_pkg::COORD_W + 4;

	localparam logic [7:0] CH_0  = "0";
	localparam logic [7:0] CH_9  = "9";
	localparam logic [7:0] CH_M  = "M";
	localparam logic [7:0] CH_EQ = "=";
	localparam logic [7:0] CH_X  = "X";
	localparam logic [7:0] CH_I  = "I";
	localparam logic [7:0] CH_S  = "S";
	localparam logic [7:0] CH_N  = "N";
	localparam logic [7:0] CH_D  = "D";
	localparam logic [7:0] CH_H  = "H";
	localparam logic [7:0] CH_P  = "P";

	cpm_pkg::coord_t                  run_q;
	logic [cpm_pkg::CHAR_W-1:0]       ch;
	logic                             accept;
	logic                             is_digit;
	cpm_pkg::op_kind_t                op;
	logic [ACC_W-1:0]                 acc;

	assign ch       = s_tdata[cpm_pkg::CHAR_W-1:0];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);

	always_comb begin
		case (ch)
			CH_M, CH_EQ, CH_X: op = cpm_pkg::OP_MATCH;
			CH_I:              op = cpm_pkg::OP_INS;
			CH_S:              op = cpm_pkg::OP_SOFT;
			CH_N, CH_D:        op = cpm_pkg::OP_REFSKIP;
			CH_H, CH_P:        op = cpm_pkg::OP_CLIP;
			default:           op = cpm_pkg::OP_NONE;
		endcase
	end

	// run * 10 + digit
	assign acc = ({4'b0, run_q} << 3) + ({4'b0, run_q} << 1) + ACC_W'(ch[3:0]);

	assign q_push         = accept && ((op != cpm_pkg::OP_NONE) || s_tlast);
	assign q_entry.op     = op;
	assign q_entry.len    = run_q;
	assign q_entry.start  = s_tdata[cpm_pkg::CHAR_W +: cpm_pkg::START_W];
	assign q_entry.offset = s_tdata[cpm_pkg::CHAR_W + cpm_pkg::START_W +: cpm_pkg::OFFSET_W];
	assign q_entry.last   = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (accept) begin
			if (s_tlast || (op != cpm_pkg::OP_NONE)) begin
				run_q <= '0;
			end else if (is_digit) begin
				run_q <= (acc > ACC_W'(cpm_pkg::COORD_MAX)) ? cpm_pkg::COORD_MAX
					: acc[cpm_pkg::COORD_W-1:0];
			end
		end
	end

endmodule

[hdl/cpm_queue.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper operation queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module cpm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cpm_pkg::entry_t  wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output cpm_pkg::entry_t  rd_entry
);

	cpm_pkg::entry_t              mem_q [cpm_pkg::Q_DEPTH];
	logic [cpm_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [cpm_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [cpm_pkg::Q_AW:0]       count_q;

	assign full     = (count_q == (cpm_pkg::Q_AW+1)'(cpm_pkg::Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/cpm_back.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper back end
// Applies operations to read length and reference position, holds result.
// ----------------------------------------------------------------------------
module cpm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  cpm_pkg::entry_t            q_entry,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cpm_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tuser
);

	logic [cpm_pkg::CNT_W-1:0]  op_count_q;
	cpm_pkg::coord_t            frag_q;
	cpm_pkg::coord_t            ref_q;
	logic                       found_q;
	cpm_pkg::coord_t            center_q;
	cpm_pkg::coord_t            first_run_q;
	logic                       out_valid_q;
	logic [cpm_pkg::OUT_W-1:0]  out_center_q;
	logic                       out_many_q;

	logic [cpm_pkg::CNT_W-1:0]  op_count_n;
	cpm_pkg::coord_t            frag_n;
	cpm_pkg::coord_t            ref_n;
	logic                       found_n;
	cpm_pkg::coord_t            center_n;
	cpm_pkg::coord_t            first_run_n;
	cpm_pkg::coord_t            ref_base;
	cpm_pkg::coord_t            start_c;
	cpm_pkg::coord_t            offset_c;
	cpm_pkg::coord_t            over;
	cpm_pkg::coord_t            result;
	logic                       is_op;
	logic                       first;

	assign q_pop = q_valid && !(q_entry.last && out_valid_q && !m_tready);

	assign start_c  = cpm_pkg::clip_start(q_entry.start);
	assign offset_c = cpm_pkg::coord_t'(q_entry.offset);
	assign is_op    = (q_entry.op != cpm_pkg::OP_NONE);
	assign first    = (op_count_q == '0);
	assign ref_base = first ? start_c : ref_q;

	always_comb begin
		op_count_n  = op_count_q;
		first_run_n = first_run_q;
		frag_n      = frag_q;
		ref_n       = ref_q;
		found_n     = found_q;
		center_n    = center_q;
		over        = '0;
		if (is_op) begin
			ref_n = ref_base;
			if (first) begin
				first_run_n = q_entry.len;
			end
			if (op_count_q != '1) begin
				op_count_n = op_count_q + 1'b1;
			end
			if (!found_q) begin
				case (q_entry.op)
					cpm_pkg::OP_MATCH: begin
						frag_n = cpm_pkg::sat_add(frag_q, q_entry.len);
						ref_n  = cpm_pkg::sat_add(ref_base, q_entry.len);
						if (frag_n > offset_c) begin
							over     = frag_n - offset_c;
							center_n = (over > ref_n) ? '0 : ref_n - over;
							found_n  = 1'b1;
						end
					end
					cpm_pkg::OP_INS: begin
						frag_n = cpm_pkg::sat_add(frag_q, q_entry.len);
					end
					cpm_pkg::OP_SOFT: begin
						frag_n = cpm_pkg::sat_add(frag_q, q_entry.len);
						if (!first) begin
							ref_n = cpm_pkg::sat_add(ref_base, q_entry.len);
						end
					end
					cpm_pkg::OP_REFSKIP: begin
						ref_n = cpm_pkg::sat_add(ref_base, q_entry.len);
					end
					default: begin
					end
				endcase
			end
		end
		if (op_count_n <= cpm_pkg::CNT_W'(1)) begin
			result = cpm_pkg::sat_add(start_c, offset_c);
		end else if (found_n) begin
			result = center_n;
		end else begin
			result = first_run_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q  <= '0;
			frag_q      <= '0;
			ref_q       <= '0;
			found_q     <= 1'b0;
			center_q    <= '0;
			first_run_q <= '0;
		end else if (q_pop) begin
			if (q_entry.last) begin
				op_count_q  <= '0;
				frag_q      <= '0;
				ref_q       <= '0;
				found_q     <= 1'b0;
				center_q    <= '0;
				first_run_q <= '0;
			end else begin
				op_count_q  <= op_count_n;
				frag_q      <= frag_n;
				ref_q       <= ref_n;
				found_q     <= found_n;
				center_q    <= center_n;
				first_run_q <= first_run_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_entry.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) begin
			out_center_q <= cpm_pkg::OUT_W'(result);
			out_many_q   <= (op_count_n > cpm_pkg::CNT_W'(3));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_center_q;
	assign m_tuser  = out_many_q;

endmodule

[hdl/cigar_psite_position_mapper_top.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site position mapper
// Input stream: one CIGAR character per item with the read start and P-site
// offset held for the string; s_tlast marks the final character.
// Output stream: one item per string, the P-site reference coordinate
// (saturated) and a flag for strings of more than three operations.
// A final character is written into the queue, then popped by the back end
// into the output register. Throughput is one item per cycle; the front end
// takes a character each cycle while the four-entry queue has room, the back
// end retires one queued operation per cycle unless a final one meets a stall.
// Reset clears the run accumulator, queue, counters and output valid flag.
// When m_tready is low the result holds; the back end keeps retiring
// non-final operations and stops only at the next final one, so s_tready
// drops once the queue fills behind it.
// ----------------------------------------------------------------------------
module cigar_psite_position_mapper_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cpm_pkg::S_DATA_W-1:0]  s_tdata,   // char_code, read_start, psite_offset
	input  logic                          s_tlast,   // last_char
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cpm_pkg::OUT_W-1:0]     m_tdata,   // center_pos
	output logic                          m_tuser    // many_regions
);

	logic             q_full;
	logic             q_push;
	cpm_pkg::entry_t  q_wr_entry;
	logic             q_pop;
	logic             q_valid;
	cpm_pkg::entry_t  q_rd_entry;

	cpm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	cpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_rd_entry)
	);

	cpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[hdl/cpm_checker.sv]
// ----------------------------------------------------------------------------
// CIGAR P-site mapper port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "cigar_psite_position_mapper_top_assert.svh"

module cpm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [cpm_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [cpm_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          m_tuser
);

	// a stalled result stays offered
	`CPM_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
	// and keeps its payload
	`CPM_ASSERT_RUN(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
	// input backs up only behind a waiting result
	`CPM_ASSERT_RUN(a_bp_cause, !s_tready |-> m_tvalid)
	// nothing offered while reset is held
	`CPM_ASSERT_ALL(a_rst_idle, !arst_n |-> !m_tvalid)

endmodule

bind cigar_psite_position_mapper_top cpm_checker u_cpm_checker (.*);
